/* rtl/ppg_pkg.sv */
// Shared types, constants and the sine table for the plasma pixel generator
package ppg_pkg;

	// Phase offset of the mirrored term (640 wraps to 128 modulo 256)
	localparam logic [7:0] MIRROR_OFFSET = 8'(640);

	// Bias that moves the wave sum from signed to unsigned
	localparam logic [9:0] SUM_BIAS = 10'(512);

	// Time base multipliers
	localparam logic [7:0] T1_MUL  = 8'd3;
	localparam logic [7:0] T2_MUL  = 8'd5;
	localparam logic [7:0] T3_MUL  = 8'd7;
	localparam logic [7:0] ROT_MUL = 8'd2;

	// Rainbow segment boundaries and slope
	localparam logic [7:0] HUE_SEG1 = 8'd43;
	localparam logic [7:0] HUE_SEG2 = 8'd85;
	localparam logic [7:0] HUE_SEG3 = 8'd128;
	localparam logic [7:0] HUE_SEG4 = 8'd170;
	localparam logic [7:0] HUE_SEG5 = 8'd213;
	localparam logic [7:0] HUE_TOP  = 8'd255;
	localparam logic [7:0] HUE_STEP = 8'd6;
	localparam logic [7:0] CH_FULL  = 8'd255;

	// Four sine phases plus palette rotation, carried from stage one
	typedef struct packed {
		logic [7:0] p0;
		logic [7:0] p1;
		logic [7:0] p2;
		logic [7:0] p3;
		logic [7:0] rot;
	} phase_t;

	// One period of sine, amplitude 127
	localparam logic signed [7:0] WAVE_ROM [256] = '{
		8'sd0, 8'sd3, 8'sd6, 8'sd9, 8'sd12, 8'sd16, 8'sd19, 8'sd22,
		8'sd25, 8'sd28, 8'sd31, 8'sd34, 8'sd37, 8'sd40, 8'sd43, 8'sd46,
		8'sd49, 8'sd51, 8'sd54, 8'sd57, 8'sd60, 8'sd63, 8'sd65, 8'sd68,
		8'sd71, 8'sd73, 8'sd76, 8'sd78, 8'sd81, 8'sd83, 8'sd85, 8'sd88,
		8'sd90, 8'sd92, 8'sd94, 8'sd96, 8'sd98, 8'sd100, 8'sd102, 8'sd104,
		8'sd106, 8'sd107, 8'sd109, 8'sd111, 8'sd112, 8'sd113, 8'sd115, 8'sd116,
		8'sd117, 8'sd118, 8'sd120, 8'sd121, 8'sd122, 8'sd122, 8'sd123, 8'sd124,
		8'sd125, 8'sd125, 8'sd126, 8'sd126, 8'sd126, 8'sd127, 8'sd127, 8'sd127,
		8'sd127, 8'sd127, 8'sd127, 8'sd127, 8'sd126, 8'sd126, 8'sd126, 8'sd125,
		8'sd125, 8'sd124, 8'sd123, 8'sd122, 8'sd122, 8'sd121, 8'sd120, 8'sd118,
		8'sd117, 8'sd116, 8'sd115, 8'sd113, 8'sd112, 8'sd111, 8'sd109, 8'sd107,
		8'sd106, 8'sd104, 8'sd102, 8'sd100, 8'sd98, 8'sd96, 8'sd94, 8'sd92,
		8'sd90, 8'sd88, 8'sd85, 8'sd83, 8'sd81, 8'sd78, 8'sd76, 8'sd73,
		8'sd71, 8'sd68, 8'sd65, 8'sd63, 8'sd60, 8'sd57, 8'sd54, 8'sd51,
		8'sd49, 8'sd46, 8'sd43, 8'sd40, 8'sd37, 8'sd34, 8'sd31, 8'sd28,
		8'sd25, 8'sd22, 8'sd19, 8'sd16, 8'sd12, 8'sd9, 8'sd6, 8'sd3,
		8'sd0, -8'sd3, -8'sd6, -8'sd9, -8'sd12, -8'sd16, -8'sd19, -8'sd22,
		-8'sd25, -8'sd28, -8'sd31, -8'sd34, -8'sd37, -8'sd40, -8'sd43, -8'sd46,
		-8'sd49, -8'sd51, -8'sd54, -8'sd57, -8'sd60, -8'sd63, -8'sd65, -8'sd68,
		-8'sd71, -8'sd73, -8'sd76, -8'sd78, -8'sd81, -8'sd83, -8'sd85, -8'sd88,
		-8'sd90, -8'sd92, -8'sd94, -8'sd96, -8'sd98, -8'sd100, -8'sd102, -8'sd104,
		-8'sd106, -8'sd107, -8'sd109, -8'sd111, -8'sd112, -8'sd113, -8'sd115, -8'sd116,
		-8'sd117, -8'sd118, -8'sd120, -8'sd121, -8'sd122, -8'sd122, -8'sd123, -8'sd124,
		-8'sd125, -8'sd125, -8'sd126, -8'sd126, -8'sd126, -8'sd127, -8'sd127, -8'sd127,
		-8'sd127, -8'sd127, -8'sd127, -8'sd127, -8'sd126, -8'sd126, -8'sd126, -8'sd125,
		-8'sd125, -8'sd124, -8'sd123, -8'sd122, -8'sd122, -8'sd121, -8'sd120, -8'sd118,
		-8'sd117, -8'sd116, -8'sd115, -8'sd113, -8'sd112, -8'sd111, -8'sd109, -8'sd107,
		-8'sd106, -8'sd104, -8'sd102, -8'sd100, -8'sd98, -8'sd96, -8'sd94, -8'sd92,
		-8'sd90, -8'sd88, -8'sd85, -8'sd83, -8'sd81, -8'sd78, -8'sd76, -8'sd73,
		-8'sd71, -8'sd68, -8'sd65, -8'sd63, -8'sd60, -8'sd57, -8'sd54, -8'sd51,
		-8'sd49, -8'sd46, -8'sd43, -8'sd40, -8'sd37, -8'sd34, -8'sd31, -8'sd28,
		-8'sd25, -8'sd22, -8'sd19, -8'sd16, -8'sd12, -8'sd9, -8'sd6, -8'sd3
	};

endpackage

/* rtl/ppg_phase.sv */
// Stage 1: time bases and the four sine phases, all modulo 256
module ppg_phase (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic [7:0]          pixel_x,
	input  logic [8:0]          pixel_y,
	input  logic [7:0]          frame_index,
	output logic                valid_s1,
	output ppg_pkg::phase_t     phase_s1
);

	logic [7:0] t1, t2, t3, rot, x2, y2;
	ppg_pkg::phase_t phase_d;

	// Only the low eight bits of every product survive
	always_comb begin
		t1  = 8'(frame_index * ppg_pkg::T1_MUL);
		t2  = 8'(frame_index * ppg_pkg::T2_MUL);
		t3  = 8'(frame_index * ppg_pkg::T3_MUL);
		rot = 8'(frame_index * ppg_pkg::ROT_MUL);
		x2  = {pixel_x[6:0], 1'b0};
		y2  = {pixel_y[6:0], 1'b0};
		phase_d.p0  = 8'(y2 + t1);
		phase_d.p1  = 8'(x2 + t2);
		phase_d.p2  = 8'(x2 + y2 + t3);
		phase_d.p3  = 8'(x2 + ppg_pkg::MIRROR_OFFSET - y2 + t1);
		phase_d.rot = rot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		phase_s1 <= phase_d;
	end

endmodule

/* rtl/ppg_wave.sv */
// Stages 2 and 3: sine lookups, then sum, bias, scale and rotate to a hue
module ppg_wave (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	input  ppg_pkg::phase_t     phase_s1,
	output logic                valid_s3,
	output logic [7:0]          hue_s3
);

	logic                valid_s2;
	logic signed [7:0]   w0_s2, w1_s2, w2_s2, w3_s2;
	logic [7:0]          rot_s2;
	logic signed [9:0]   sum;
	logic [9:0]          biased;
	logic [7:0]          idx;

	// Stage 2: four table reads
	always_ff @(posedge clk) begin
		w0_s2  <= ppg_pkg::WAVE_ROM[phase_s1.p0];
		w1_s2  <= ppg_pkg::WAVE_ROM[phase_s1.p1];
		w2_s2  <= ppg_pkg::WAVE_ROM[phase_s1.p2];
		w3_s2  <= ppg_pkg::WAVE_ROM[phase_s1.p3];
		rot_s2 <= phase_s1.rot;
	end

	// Sum lies in -508..508; bias to 4..1020, drop two bits, rotate
	always_comb begin
		sum    = 10'(w0_s2) + 10'(w1_s2) + 10'(w2_s2) + 10'(w3_s2);
		biased = 10'(sum) + ppg_pkg::SUM_BIAS;
		idx    = biased[9:2];
	end

	always_ff @(posedge clk) begin
		hue_s3 <= 8'(idx + rot_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

endmodule

/* rtl/ppg_hue.sv */
// Stage 4: six-segment rainbow, hue to RGB565
module ppg_hue (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         valid_s3,
	input  logic [7:0]   hue_s3,
	output logic         valid_s4,
	output logic [15:0]  color_s4
);

	logic [7:0] r, g, b;

	// Each ramp term stays below 43, so times six fits eight bits
	always_comb begin
		if (hue_s3 < ppg_pkg::HUE_SEG1) begin
			r = ppg_pkg::CH_FULL;
			g = 8'(hue_s3 * ppg_pkg::HUE_STEP);
			b = '0;
		end else if (hue_s3 < ppg_pkg::HUE_SEG2) begin
			r = 8'((ppg_pkg::HUE_SEG2 - hue_s3) * ppg_pkg::HUE_STEP);
			g = ppg_pkg::CH_FULL;
			b = '0;
		end else if (hue_s3 < ppg_pkg::HUE_SEG3) begin
			r = '0;
			g = ppg_pkg::CH_FULL;
			b = 8'((hue_s3 - ppg_pkg::HUE_SEG2) * ppg_pkg::HUE_STEP);
		end else if (hue_s3 < ppg_pkg::HUE_SEG4) begin
			r = '0;
			g = 8'((ppg_pkg::HUE_SEG4 - hue_s3) * ppg_pkg::HUE_STEP);
			b = ppg_pkg::CH_FULL;
		end else if (hue_s3 < ppg_pkg::HUE_SEG5) begin
			r = 8'((hue_s3 - ppg_pkg::HUE_SEG4) * ppg_pkg::HUE_STEP);
			g = '0;
			b = ppg_pkg::CH_FULL;
		end else begin
			r = ppg_pkg::CH_FULL;
			g = '0;
			b = 8'((ppg_pkg::HUE_TOP - hue_s3) * ppg_pkg::HUE_STEP);
		end
	end

	always_ff @(posedge clk) begin
		color_s4 <= {r[7:3], g[7:2], b[7:3]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= valid_s3;
		end
	end

endmodule

/* rtl/plasma_pixel_generator.sv */
// Channel   Ports                                    Handshake
// -------   ---------------------------------------  -------------------------
// pixel in  pixel_x[7:0] pixel_y[8:0] frame_index[7:0] taken when start && !busy
// colour    pixel_color[15:0]                        one cycle, marked by done
//
// Four register stages: phases, sine lookups, sum and rotate, rainbow.
// One item is taken every cycle; its colour leaves the rainbow stage, marked by done.
// busy stays low: the pipeline always moves, nothing waits on the receiver.
// Reset clears the stage valid bits only; no item is in flight after it.
module plasma_pixel_generator (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	output logic         busy,
	input  logic [7:0]   pixel_x,
	input  logic [8:0]   pixel_y,
	input  logic [7:0]   frame_index,
	output logic         done,
	output logic [15:0]  pixel_color
);

	logic             accept;
	logic             valid_s1, valid_s3;
	ppg_pkg::phase_t  phase_s1;
	logic [7:0]       hue_s3;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	ppg_phase u_phase (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (accept),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.frame_index (frame_index),
		.valid_s1    (valid_s1),
		.phase_s1    (phase_s1)
	);

	ppg_wave u_wave (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.phase_s1 (phase_s1),
		.valid_s3 (valid_s3),
		.hue_s3   (hue_s3)
	);

	ppg_hue u_hue (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s3 (valid_s3),
		.hue_s3   (hue_s3),
		.valid_s4 (done),
		.color_s4 (pixel_color)
	);

endmodule
